>>> rtl/core/deq_pkg.sv
// Shared types and codes for the double-ended queue with search.
package deq_pkg;

	localparam int unsigned VAL_W = 32;

	typedef enum logic [2:0] {
		FN_PUSH_FRONT = 3'd0,
		FN_PUSH_BACK  = 3'd1,
		FN_POP_FRONT  = 3'd2,
		FN_POP_BACK   = 3'd3,
		FN_SEARCH     = 3'd4
	} func_t;

	typedef enum logic [1:0] {
		STAT_DONE  = 2'd0,
		STAT_EMPTY = 2'd1,
		STAT_FULL  = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;     // request transaction taken this cycle
		logic srch_run;   // search scan in progress
		logic load_srch;  // load the finished search result
	} ctrl_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic start_srch; // presented request is a search of a nonempty queue
		logic srch_done;  // scan finished this cycle
		logic slot_free;  // result stage can take a result this cycle
	} dp_stat_t;

endpackage

>>> rtl/core/deq_ifs.sv
// Request and response channel interfaces of the queue.
interface deq_req_if;
	logic                          valid;
	logic                          ready;
	deq_pkg::func_t                func;
	logic signed [deq_pkg::VAL_W-1:0] value;

	modport source (output valid, output func, output value, input ready);
	modport sink (input valid, input func, input value, output ready);
endinterface

interface deq_rsp_if #(
	parameter int unsigned OCC_W = 5
);
	logic             valid;
	logic             ready;
	deq_pkg::status_t status;
	logic             found;
	logic [OCC_W-1:0] occupancy;

	modport source (output valid, output status, output found, output occupancy, input ready);
	modport sink (input valid, input status, input found, input occupancy, output ready);
endinterface

>>> rtl/core/deq_ram.sv
// Generic single-port RAM with registered read data.
module deq_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

>>> rtl/core/deq_ctrl.sv
// Controller state machine: request acceptance and search sequencing.
module deq_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               req_valid,
	output logic               req_ready,
	input  deq_pkg::dp_stat_t  stat,
	output deq_pkg::ctrl_cmd_t cmd
);
	import deq_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_SRCH = 3'b010,
		ST_DONE = 3'b100
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		req_ready     = 1'b0;
		cmd.accept    = 1'b0;
		cmd.srch_run  = 1'b0;
		cmd.load_srch = 1'b0;
		state_d       = state_q;
		unique case (state_q)
			ST_IDLE: begin
				req_ready  = stat.slot_free;
				cmd.accept = req_valid && stat.slot_free;
				if (cmd.accept && stat.start_srch) begin
					state_d = ST_SRCH;
				end
			end
			ST_SRCH: begin
				cmd.srch_run = 1'b1;
				if (stat.srch_done) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				// hold the search result until the result stage frees up
				if (stat.slot_free) begin
					cmd.load_srch = 1'b1;
					state_d       = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

>>> rtl/core/deq_dp.sv
// Datapath: queue pointers, entry store, search scan and result registers.
module deq_dp #(
	parameter int unsigned CAPACITY = 16,
	parameter int unsigned OCC_W    = 5
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  deq_pkg::ctrl_cmd_t                cmd,
	output deq_pkg::dp_stat_t                 stat,
	input  deq_pkg::func_t                    func,
	input  logic signed [deq_pkg::VAL_W-1:0]  value,
	input  logic                              rsp_ready,
	output logic                              rsp_valid,
	output deq_pkg::status_t                  rsp_status,
	output logic                              rsp_found,
	output logic [OCC_W-1:0]                  rsp_occupancy
);
	import deq_pkg::*;

	localparam int unsigned IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int unsigned SUM_W = IDX_W + 1;

	logic [IDX_W-1:0] front_q;
	logic [OCC_W-1:0] count_q;

	logic [IDX_W-1:0] front_dec, front_inc, back_pos, ptr_inc;
	logic [SUM_W-1:0] back_sum;
	logic             full, empty;

	// scan state
	logic [IDX_W-1:0] ptr_q;
	logic [OCC_W-1:0] issued_q, cmp_q;
	logic [VAL_W-1:0] key_q;
	logic             rdv_s1, found_q, issue, hit;

	// RAM port
	logic             ram_we;
	logic [IDX_W-1:0] ram_addr;
	logic [VAL_W-1:0] ram_rdata;

	// next state and result of a single-step request
	logic [IDX_W-1:0] front_nx;
	logic [OCC_W-1:0] count_nx;
	status_t          stat_nx;

	// result stage and output register
	logic             res_valid_s1;
	status_t          res_status_s1;
	logic             res_found_s1;
	logic [OCC_W-1:0] res_occ_s1;
	logic             out_valid_q;
	status_t          out_status_q;
	logic             out_found_q;
	logic [OCC_W-1:0] out_occ_q;
	logic             out_free, move, load;

	assign full      = count_q == OCC_W'(CAPACITY);
	assign empty     = count_q == '0;
	assign front_dec = (front_q == '0) ? IDX_W'(CAPACITY - 1) : front_q - IDX_W'(1);
	assign front_inc = (front_q == IDX_W'(CAPACITY - 1)) ? '0 : front_q + IDX_W'(1);
	assign ptr_inc   = (ptr_q == IDX_W'(CAPACITY - 1)) ? '0 : ptr_q + IDX_W'(1);
	assign back_sum  = SUM_W'(front_q) + SUM_W'(count_q);
	assign back_pos  = (back_sum >= SUM_W'(CAPACITY)) ?
		IDX_W'(back_sum - SUM_W'(CAPACITY)) : IDX_W'(back_sum);

	always_comb begin
		front_nx = front_q;
		count_nx = count_q;
		stat_nx  = STAT_DONE;
		ram_we   = 1'b0;
		ram_addr = ptr_q;
		unique case (func)
			FN_PUSH_FRONT: begin
				if (full) begin
					stat_nx = STAT_FULL;
				end else begin
					front_nx = front_dec;
					count_nx = count_q + OCC_W'(1);
					ram_we   = cmd.accept;
					ram_addr = front_dec;
				end
			end
			FN_PUSH_BACK: begin
				if (full) begin
					stat_nx = STAT_FULL;
				end else begin
					count_nx = count_q + OCC_W'(1);
					ram_we   = cmd.accept;
					ram_addr = back_pos;
				end
			end
			FN_POP_FRONT: begin
				if (empty) begin
					stat_nx = STAT_EMPTY;
				end else begin
					front_nx = front_inc;
					count_nx = count_q - OCC_W'(1);
				end
			end
			FN_POP_BACK: begin
				if (empty) begin
					stat_nx = STAT_EMPTY;
				end else begin
					count_nx = count_q - OCC_W'(1);
				end
			end
			FN_SEARCH: begin
				if (empty) begin
					stat_nx = STAT_EMPTY;
				end
			end
			default: begin
			end
		endcase
		// the scan owns the port while it runs
		if (cmd.srch_run) begin
			ram_we   = 1'b0;
			ram_addr = ptr_q;
		end
	end

	deq_ram #(
		.WIDTH(VAL_W),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(value),
		.rdata(ram_rdata)
	);

	assign issue = cmd.srch_run && (issued_q != count_q);
	assign hit   = ram_rdata == key_q;

	assign stat.start_srch = (func == FN_SEARCH) && !empty;
	assign stat.srch_done  = cmd.srch_run && rdv_s1 && (hit || (cmp_q + OCC_W'(1) == count_q));

	assign out_free       = !out_valid_q || rsp_ready;
	assign move           = res_valid_s1 && out_free;
	assign stat.slot_free = !res_valid_s1 || out_free;
	assign load           = (cmd.accept && !stat.start_srch) || cmd.load_srch;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q      <= '0;
			count_q      <= '0;
			rdv_s1       <= 1'b0;
			res_valid_s1 <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.accept) begin
				front_q <= front_nx;
				count_q <= count_nx;
			end
			rdv_s1 <= issue && !stat.srch_done;
			if (load) begin
				res_valid_s1 <= 1'b1;
			end else if (move) begin
				res_valid_s1 <= 1'b0;
			end
			if (move) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q    <= value;
			ptr_q    <= front_q;
			issued_q <= '0;
			cmp_q    <= '0;
		end else if (cmd.srch_run) begin
			if (issue) begin
				ptr_q    <= ptr_inc;
				issued_q <= issued_q + OCC_W'(1);
			end
			if (rdv_s1) begin
				cmp_q <= cmp_q + OCC_W'(1);
			end
		end
		if (stat.srch_done) begin
			found_q <= hit;
		end
		if (load) begin
			if (cmd.load_srch) begin
				res_status_s1 <= STAT_DONE;
				res_found_s1  <= found_q;
				res_occ_s1    <= count_q;
			end else begin
				res_status_s1 <= stat_nx;
				res_found_s1  <= 1'b0;
				res_occ_s1    <= count_nx;
			end
		end
		if (move) begin
			out_status_q <= res_status_s1;
			out_found_q  <= res_found_s1;
			out_occ_q    <= res_occ_s1;
		end
	end

	assign rsp_valid     = out_valid_q;
	assign rsp_status    = out_status_q;
	assign rsp_found     = out_found_q;
	assign rsp_occupancy = out_occ_q;

endmodule

>>> rtl/core/deque_with_search.sv
// Top level of the bounded double-ended queue with search.
//
// Usage: requests arrive on the req channel (func, value) and each one yields
// exactly one response transaction on rsp (status, found, occupancy), in order.
// func selects push front, push back, pop front, pop back or search; pops only
// discard the entry. A push into a full queue is dropped with a full status;
// a pop or search of an empty queue reports an empty status. Unused codes
// change nothing and answer with a done status.
//
// Flow: push, pop and unused codes complete in the datapath when accepted; the
// response passes through the result stage and the output register to rsp.
// A search scans the held entries front to back through the single port of
// the entry RAM, one read per cycle, and ends at the first match; no request
// is accepted until its result enters the result stage.
// A result stage sits in front of the output register, so one more request is
// accepted while a finished response waits on a stalled rsp; after that req
// holds ready low until the receiver drains rsp.
//
// Reset (arst_n low) empties the queue and drops any pending response. The
// entry RAM is not cleared; only entries written by a push are ever read.
module deque_with_search #(
	parameter int unsigned CAPACITY = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	deq_req_if.sink     req,
	deq_rsp_if.source   rsp
);
	import deq_pkg::*;

	localparam int unsigned OCC_W = $clog2(CAPACITY + 1);

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	// Sequence acceptance and the search scan.
	deq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req.valid),
		.req_ready(req.ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// Hold the queue state, the entry RAM and the response registers.
	deq_dp #(
		.CAPACITY(CAPACITY),
		.OCC_W   (OCC_W)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.func         (req.func),
		.value        (req.value),
		.rsp_ready    (rsp.ready),
		.rsp_valid    (rsp.valid),
		.rsp_status   (rsp.status),
		.rsp_found    (rsp.found),
		.rsp_occupancy(rsp.occupancy)
	);

endmodule
